/* sv/cqc_pkg.sv */
package cqc_pkg;

    localparam logic [63:0] FIB_MUL   = 64'd11400714819323198485;
    localparam logic [63:0] OVF_LIMIT = 64'hFFFF_FFFF_FFFF_FFFE;

    localparam logic [2:0] OUT_ONE      = 3'd0;
    localparam logic [2:0] OUT_CYCLE    = 3'd1;
    localparam logic [2:0] OUT_DIVERGE  = 3'd2;
    localparam logic [2:0] OUT_INCONCL  = 3'd3;
    localparam logic [2:0] OUT_OVF_SKIP = 3'd4;

    localparam logic [1:0] CFG_Q       = 2'd0;
    localparam logic [1:0] CFG_LIMIT   = 2'd1;
    localparam logic [1:0] CFG_THRESH  = 2'd2;
    localparam logic [1:0] CFG_MINSTEP = 2'd3;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_CLEAR = 11'b000_0000_0010,
        S_TEST  = 11'b000_0000_0100,
        S_HASH  = 11'b000_0000_1000,
        S_PROBE = 11'b000_0001_0000,
        S_CHECK = 11'b000_0010_0000,
        S_OVF   = 11'b000_0100_0000,
        S_MUL   = 11'b000_1000_0000,
        S_MIN   = 11'b001_0000_0000,
        S_MINW  = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } t_state;

endpackage

/* sv/cqc_ram.sv */
module cqc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* sv/cqc_mul32.sv */
// 64x64 low-half product from three 32x32 partial products (high-by-high is not needed), one per cycle.
module cqc_mul32 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_prod
);
    logic [63:0] r_a, r_b, r_acc;
    logic [2:0]  r_cnt;
    logic        r_busy;
    logic [31:0] w_x, w_y;
    logic [63:0] w_pp;

    always_comb begin
        w_x = r_cnt[1] ? r_a[63:32] : r_a[31:0];
        w_y = r_cnt[0] ? r_b[63:32] : r_b[31:0];
    end
    assign w_pp = 64'(w_x) * 64'(w_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_a <= i_a; r_b <= i_b; r_acc <= '0; r_cnt <= '0; r_busy <= 1'b1;
            end else if (r_busy) begin
                case (r_cnt[1:0])
                    2'd0: r_acc <= r_acc + w_pp;
                    2'd1, 2'd2: r_acc <= r_acc + {w_pp[31:0], 32'd0};
                    default: ;
                endcase
                if (r_cnt == 3'd3) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end
    assign o_prod = r_acc;
endmodule

/* sv/collatz_qn1_cycle_classifier_top.sv */
// Classifies one q*n+1 trajectory per start value. Each walk first clears the
// hash occupancy memory, one slot per cycle. Each map step then waits on the
// partial-product hash multiply, probes the slot memories with a registered
// read (once more for each extra probe), and for odd values waits on the
// multiply by q. A detected cycle walks its path entries through S_MIN and
// S_MINW to find its smallest member, and S_OUT then presents the result.
// Results sit in an output register until taken, and no new start value is
// accepted while one is waiting.
module collatz_qn1_cycle_classifier_top #(
    parameter int HASH_SLOTS = 131072,
    parameter int PATH_DEPTH = 32768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_start_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_outcome,
    output logic [15:0] o_step_count,
    output logic [15:0] o_cycle_length,
    output logic [63:0] o_cycle_min
);
    import cqc_pkg::*;

    localparam int HW = $clog2(HASH_SLOTS);
    localparam int PW = $clog2(PATH_DEPTH);
    localparam int LIM = (PATH_DEPTH < HASH_SLOTS) ? PATH_DEPTH : HASH_SLOTS;

    t_state r_state;
    logic [9:0]  r_q;
    logic [15:0] r_limit, r_minstep;
    logic [63:0] r_thresh;
    logic [63:0] r_n, r_min;
    logic [16:0] r_step, r_elim, r_k;
    logic [HW-1:0] r_slot;
    logic        r_ovf_ok;
    logic        r_outv;

    // occupancy, key, step memories share address
    logic          w_used_rd, w_used_we, w_used_wd;
    logic [63:0]   w_key_rd;
    logic [15:0]   w_stp_rd;
    logic          w_kw_we;
    logic [HW-1:0] w_haddr;
    logic [63:0]   w_path_rd;
    logic          w_path_we;
    logic [PW-1:0] w_praddr;
    logic [PW-1:0] w_pwaddr;
    // full q*n, overflow when it reaches 2^64 - 1
    logic [73:0]   w_qn;

    logic        w_mstart, w_mdone;
    logic [63:0] w_ma, w_mb, w_mprod;

    always_comb begin
        w_haddr   = r_slot;
        w_used_we = (r_state == S_CLEAR) ||
                    (r_state == S_CHECK && !w_used_rd);
        w_used_wd = (r_state == S_CHECK);
        w_kw_we   = (r_state == S_CHECK) && !w_used_rd;
        w_path_we = w_kw_we;
        w_praddr  = PW'(r_k);
        w_pwaddr  = PW'(r_step);
        w_qn      = 74'(r_n) * 74'(r_q);
        w_mstart  = 1'b0;
        w_ma      = r_n;
        w_mb      = FIB_MUL;
        if (r_state == S_TEST && r_n != 64'd1 && r_step < r_elim) w_mstart = 1'b1;
        if (r_state == S_OVF && r_ovf_ok && r_n[0]) begin
            w_mstart = 1'b1;
            w_mb = {54'd0, r_q};
        end
    end

    cqc_ram #(.WIDTH(1), .DEPTH(HASH_SLOTS)) u_used (
        .i_clk, .i_we(w_used_we), .i_waddr(w_haddr), .i_wdata(w_used_wd),
        .i_raddr(w_haddr), .o_rdata(w_used_rd));
    cqc_ram #(.WIDTH(64), .DEPTH(HASH_SLOTS)) u_key (
        .i_clk, .i_we(w_kw_we), .i_waddr(w_haddr), .i_wdata(r_n),
        .i_raddr(w_haddr), .o_rdata(w_key_rd));
    cqc_ram #(.WIDTH(16), .DEPTH(HASH_SLOTS)) u_stp (
        .i_clk, .i_we(w_kw_we), .i_waddr(w_haddr), .i_wdata(r_step[15:0]),
        .i_raddr(w_haddr), .o_rdata(w_stp_rd));
    cqc_ram #(.WIDTH(64), .DEPTH(PATH_DEPTH)) u_path (
        .i_clk, .i_we(w_path_we), .i_waddr(w_pwaddr), .i_wdata(r_n),
        .i_raddr(w_praddr), .o_rdata(w_path_rd));

    cqc_mul32 u_mul (
        .i_clk, .i_rst_n, .i_start(w_mstart), .i_a(w_ma), .i_b(w_mb),
        .o_done(w_mdone), .o_prod(w_mprod));

    assign o_ready = (r_state == S_IDLE) && !r_outv;
    assign o_valid = r_outv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_outv    <= 1'b0;
            r_q       <= 10'd5;
            r_limit   <= 16'd20000;
            r_thresh  <= 64'd100000000000000000;
            r_minstep <= 16'd30;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_Q:       r_q       <= i_cfg_data[9:0];
                    CFG_LIMIT:   r_limit   <= i_cfg_data[15:0];
                    CFG_THRESH:  r_thresh  <= i_cfg_data;
                    CFG_MINSTEP: r_minstep <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (r_outv && i_ready) r_outv <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_n    <= i_start_value;
                        r_step <= '0;
                        r_slot <= '0;
                        r_elim <= (32'(r_limit) > LIM) ? 17'(LIM) : 17'(r_limit);
                        r_state <= S_CLEAR;
                    end
                end
                S_CLEAR: begin
                    r_slot <= r_slot + 1'b1;
                    if (r_slot == HW'(HASH_SLOTS - 1)) r_state <= S_TEST;
                end
                S_TEST: begin
                    if (r_step >= r_elim) begin
                        o_outcome <= OUT_INCONCL; o_step_count <= r_elim[15:0];
                        o_cycle_length <= '0; o_cycle_min <= '0; r_state <= S_OUT;
                    end else if (r_n == 64'd1) begin
                        o_outcome <= OUT_ONE; o_step_count <= r_step[15:0];
                        o_cycle_length <= '0; o_cycle_min <= '0; r_state <= S_OUT;
                    end else begin
                        r_ovf_ok <= (w_qn[73:64] == '0) && (w_qn[63:0] != '1);
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (w_mdone) begin
                        r_slot  <= w_mprod[32 +: HW];
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: r_state <= S_CHECK;
                S_CHECK: begin
                    if (!w_used_rd) begin
                        r_state <= S_OVF;
                    end else if (w_key_rd == r_n) begin
                        r_k     <= {1'b0, w_stp_rd};
                        r_min   <= r_n;
                        o_cycle_length <= r_step[15:0] - w_stp_rd;
                        o_step_count   <= r_step[15:0];
                        o_outcome      <= OUT_CYCLE;
                        r_state <= S_MIN;
                    end else begin
                        r_slot  <= r_slot + 1'b1;
                        r_state <= S_PROBE;
                    end
                end
                S_OVF: begin
                    if (!r_n[0]) begin
                        r_state <= S_MUL;
                    end else if (!r_ovf_ok) begin
                        o_outcome <= (r_step > 17'(r_minstep)) ? OUT_DIVERGE : OUT_OVF_SKIP;
                        o_step_count <= r_step[15:0];
                        o_cycle_length <= '0; o_cycle_min <= '0; r_state <= S_OUT;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (!r_n[0] || w_mdone) begin
                        logic [63:0] v;
                        v = r_n[0] ? w_mprod + 64'd1 : r_n >> 1;
                        r_n <= v;
                        if (v > r_thresh && r_step > 17'(r_minstep)) begin
                            o_outcome <= OUT_DIVERGE; o_step_count <= r_step[15:0] + 16'd1;
                            o_cycle_length <= '0; o_cycle_min <= '0; r_state <= S_OUT;
                        end else begin
                            r_step <= r_step + 17'd1;
                            r_state <= S_TEST;
                        end
                    end
                end
                S_MIN: begin
                    if (r_k >= r_step) begin
                        o_cycle_min <= r_min;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MINW;
                    end
                end
                S_MINW: begin
                    if (w_path_rd < r_min) r_min <= w_path_rd;
                    r_k <= r_k + 17'd1;
                    r_state <= S_MIN;
                end
                S_OUT: begin
                    r_outv  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
